>>> design/amdfs_pkg.sv
`timescale 1ns / 1ps

package amdfs_pkg;

   localparam int VERTEX_COUNT  = 16;
   localparam int STACK_ENTRIES = 256;
   localparam int VERTEX_W      = $clog2(VERTEX_COUNT);
   localparam int STACK_AW      = $clog2(STACK_ENTRIES);
   localparam int COUNT_W       = STACK_AW + 1;
   localparam int MODE_W        = 2;
   localparam int STEP_W        = 3;

   typedef logic [VERTEX_W-1:0]     vertex_type;
   typedef logic [VERTEX_COUNT-1:0] row_type;
   typedef logic [STEP_W-1:0]       step_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // jump conditions of a control word
   typedef enum logic [2:0] {
      COND_NEVER     = 3'd0,
      COND_ALWAYS    = 3'd1,
      COND_NO_REQ    = 3'd2,
      COND_EMPTY     = 3'd3,
      COND_SEEN      = 3'd4,
      COND_SCAN_MORE = 3'd5
   } cond_type;

   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_POP    = 3'd1;
   localparam step_type STEP_TEST   = 3'd2;
   localparam step_type STEP_SCAN   = 3'd3;
   localparam step_type STEP_LOOP   = 3'd4;
   localparam step_type STEP_FINISH = 3'd5;

   typedef struct packed {
      logic     busy;
      logic     take;
      logic     pop;
      logic     visit;
      logic     scan;
      logic     finish;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic search_req;
      logic empty;
      logic seen;
      logic scan_more;
   } status_type;

   // control store: one word per step
   function automatic ctrl_type ucode(step_type step);
      ctrl_type w;
      w = '{busy: 1'b1, take: 1'b0, pop: 1'b0, visit: 1'b0, scan: 1'b0,
            finish: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            w.busy   = 1'b0;
            w.take   = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = STEP_IDLE;
         end
         STEP_POP: begin
            w.pop    = 1'b1;
            w.cond   = COND_EMPTY;
            w.target = STEP_FINISH;
         end
         STEP_TEST: begin
            w.visit  = 1'b1;
            w.cond   = COND_SEEN;
            w.target = STEP_POP;
         end
         STEP_SCAN: begin
            w.scan   = 1'b1;
            w.cond   = COND_SCAN_MORE;
            w.target = STEP_SCAN;
         end
         STEP_LOOP: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_POP;
         end
         STEP_FINISH: begin
            w.finish = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> design/amdfs_sequencer.sv
`timescale 1ns / 1ps

module amdfs_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  amdfs_pkg::status_type status,
   output amdfs_pkg::ctrl_type   ctrl
);
   import amdfs_pkg::*;

   step_type pc_ff;
   step_type pc_in;
   logic     jump;

   assign ctrl = ucode(pc_ff);

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:     jump = 1'b0;
         COND_ALWAYS:    jump = 1'b1;
         COND_NO_REQ:    jump = !status.search_req;
         COND_EMPTY:     jump = status.empty;
         COND_SEEN:      jump = status.seen;
         COND_SCAN_MORE: jump = status.scan_more;
         default:        jump = 1'b1;
      endcase
      pc_in = jump ? ctrl.target : step_type'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> design/amdfs_datapath.sv
`timescale 1ns / 1ps

module amdfs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  amdfs_pkg::ctrl_type    ctrl,
   input  logic                   start,
   input  logic [1:0]             req_mode,
   input  amdfs_pkg::vertex_type  req_source_vertex,
   input  amdfs_pkg::vertex_type  req_target_vertex,
   output amdfs_pkg::status_type  status,
   output logic                   rsp_valid,
   output amdfs_pkg::vertex_type  rsp_visited_vertex,
   output logic                   rsp_last_visit
);
   import amdfs_pkg::*;

   row_type              edge_ff [VERTEX_COUNT];
   row_type              visited_ff;
   logic [COUNT_W-1:0]   sp_ff;
   vertex_type           top_ff;
   vertex_type           cur_ff;
   vertex_type           scan_ff;
   vertex_type           held_ff;
   logic                 held_valid_ff;
   logic                 rsp_valid_ff;
   vertex_type           rsp_vertex_ff;
   logic                 rsp_last_ff;
   vertex_type           stack_mem [STACK_ENTRIES];

   logic                 take_edge;
   logic                 take_search;
   logic                 pop_en;
   logic                 visit_en;
   logic                 push_en;
   logic                 emit;
   logic [STACK_AW-1:0]  pop_addr;
   logic                 rsp_valid_in;

   assign take_edge   = ctrl.take && start &&
                        (req_mode == MODE_ADD || req_mode == MODE_REMOVE);
   assign take_search = ctrl.take && start && req_mode == MODE_SEARCH;

   assign status.search_req = start && req_mode == MODE_SEARCH;
   assign status.empty      = sp_ff == '0;
   assign status.seen       = visited_ff[top_ff];
   assign status.scan_more  = scan_ff != vertex_type'(VERTEX_COUNT - 1);

   assign pop_en   = ctrl.pop && !status.empty;
   assign pop_addr = sp_ff[STACK_AW-1:0] - 1'b1;
   assign visit_en = ctrl.visit && !status.seen;
   assign push_en  = ctrl.scan && edge_ff[cur_ff][scan_ff] && scan_ff != cur_ff &&
                     !visited_ff[scan_ff] && sp_ff < COUNT_W'(STACK_ENTRIES);
   // a held vertex goes out once the next one is known, or flagged last at the end
   assign emit         = (visit_en || ctrl.finish) && held_valid_ff;
   assign rsp_valid_in = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < VERTEX_COUNT; r++) begin
            edge_ff[r] <= '0;
         end
         visited_ff    <= '0;
         sp_ff         <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take_edge) begin
            edge_ff[req_source_vertex][req_target_vertex] <= (req_mode == MODE_ADD);
         end
         if (take_search) begin
            visited_ff    <= '0;
            sp_ff         <= COUNT_W'(1);
            held_valid_ff <= 1'b0;
         end else begin
            if (pop_en) begin
               sp_ff <= sp_ff - 1'b1;
            end else if (push_en) begin
               sp_ff <= sp_ff + 1'b1;
            end
            if (visit_en) begin
               visited_ff[top_ff] <= 1'b1;
               held_valid_ff      <= 1'b1;
            end else if (ctrl.finish) begin
               held_valid_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_search) begin
         stack_mem[0] <= req_source_vertex;
      end else if (push_en) begin
         stack_mem[sp_ff[STACK_AW-1:0]] <= scan_ff;
      end
      if (pop_en) begin
         top_ff <= stack_mem[pop_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (visit_en) begin
         cur_ff  <= top_ff;
         held_ff <= top_ff;
         scan_ff <= '0;
      end else if (ctrl.scan) begin
         scan_ff <= scan_ff + 1'b1;
      end
      if (emit) begin
         rsp_vertex_ff <= held_ff;
         rsp_last_ff   <= ctrl.finish;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_visited_vertex = rsp_vertex_ff;
   assign rsp_last_visit     = rsp_last_ff;

endmodule

>>> design/adjacency_matrix_dfs_unit.sv
`timescale 1ns / 1ps

// Depth-first search over a 16-vertex directed adjacency bit matrix. An edge add or
// remove is taken while idle and busy stays low. A search from req_source_vertex
// raises busy and sends one rsp_valid strobe per visited vertex, in visit order; the
// last one carries rsp_last_visit and arrives as busy drops. Results cannot be held
// off by the receiver. The microcoded sequencer pops the stack, tests the popped vertex,
// and for an unvisited one scans one matrix column per cycle, pushing unvisited
// neighbors; an empty stack ends the search. The stack is a single-port memory read
// one entry per pop.
module adjacency_matrix_dfs_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_mode,
   input  amdfs_pkg::vertex_type req_source_vertex,
   input  amdfs_pkg::vertex_type req_target_vertex,
   output logic                  rsp_valid,
   output amdfs_pkg::vertex_type rsp_visited_vertex,
   output logic                  rsp_last_visit
);
   import amdfs_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   amdfs_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   amdfs_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .start              (start),
      .req_mode           (req_mode),
      .req_source_vertex  (req_source_vertex),
      .req_target_vertex  (req_target_vertex),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_visited_vertex (rsp_visited_vertex),
      .rsp_last_visit     (rsp_last_visit)
   );

   assign busy = ctrl.busy;

   a_last_ends_search : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_visit == !busy))
      else $error("last visit flag out of step with busy");

   a_search_goes_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == MODE_SEARCH |=> busy)
      else $error("search transfer did not start the sequencer");

   a_edge_write_idle : assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == MODE_ADD || req_mode == MODE_REMOVE) |=> !busy)
      else $error("edge write left the block busy");

   a_idle_no_result : assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_valid)
      else $error("result strobe outside a search");

endmodule

>>> dv/adjacency_matrix_dfs_unit_test.sv
`timescale 1ns / 1ps

module adjacency_matrix_dfs_unit_test;
   import amdfs_pkg::*;

   localparam int RANDOM_ITEMS = 380;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      vertex_type vertex;
      logic       last;
   } visit_type;

   class dfs_scoreboard;
      row_type   edge_rows [VERTEX_COUNT];
      visit_type expected_visits [$];
      int        errors;
      int        checked;

      function new();
         foreach (edge_rows[i]) edge_rows[i] = '0;
         errors  = 0;
         checked = 0;
      endfunction

      // Apply an accepted command to the shadow matrix, or predict the visit order.
      function void note_item(mode_type m, vertex_type s, vertex_type t);
         row_type    seen;
         vertex_type pending [STACK_ENTRIES];
         int         depth;
         vertex_type v;
         visit_type  next_visit;
         case (m)
            MODE_ADD:    edge_rows[s][t] = 1'b1;
            MODE_REMOVE: edge_rows[s][t] = 1'b0;
            MODE_SEARCH: begin
               seen       = '0;
               pending[0] = s;
               depth      = 1;
               while (depth > 0) begin
                  depth--;
                  v = pending[depth];
                  if (seen[v]) continue;
                  seen[v] = 1'b1;
                  next_visit.vertex = v;
                  next_visit.last   = 1'b0;
                  expected_visits.insert(expected_visits.size(), next_visit);
                  // push ascending so the highest neighbor pops first
                  for (int j = 0; j < VERTEX_COUNT; j++) begin
                     if (j != v && edge_rows[v][j] && !seen[j] && depth < STACK_ENTRIES) begin
                        pending[depth] = vertex_type'(j);
                        depth++;
                     end
                  end
               end
               expected_visits[expected_visits.size() - 1].last = 1'b1;
            end
            default: ;
         endcase
      endfunction

      function void check_visit(vertex_type v, logic last);
         visit_type exp_visit;
         if (expected_visits.size() == 0) begin
            errors++;
            $display("%0t: unexpected visit, expected none, got vertex %0d last %0b",
                     $time, v, last);
            return;
         end
         exp_visit = expected_visits.pop_front();
         checked++;
         if (v !== exp_visit.vertex) begin
            errors++;
            $display("%0t: visited_vertex mismatch, expected %0d, got %0d",
                     $time, exp_visit.vertex, v);
         end
         if (last !== exp_visit.last) begin
            errors++;
            $display("%0t: last_visit mismatch, expected %0b, got %0b",
                     $time, exp_visit.last, last);
         end
      endfunction

      function int pending_visits();
         return expected_visits.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   mode_type   req_mode;
   vertex_type req_source_vertex;
   vertex_type req_target_vertex;
   logic       rsp_valid;
   vertex_type rsp_visited_vertex;
   logic       rsp_last_visit;

   dfs_scoreboard visit_board;
   int            cycle_count;
   int            edge_writes;
   int            searches;
   int            ignored;
   int            steady_left;

   adjacency_matrix_dfs_unit uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_source_vertex  (req_source_vertex),
      .req_target_vertex  (req_target_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_visited_vertex (rsp_visited_vertex),
      .rsp_last_visit     (rsp_last_visit)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** adjacency_matrix_dfs_unit: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) visit_board.check_visit(rsp_visited_vertex, rsp_last_visit);
   end

   // Drop start for a random gap; mostly short, now and then long, none in steady stretches.
   task automatic idle_gap();
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (steady_left > 0) begin
         steady_left--;
         gap = 0;
      end else if (r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Present one command and hold it until the transfer completes.
   task automatic issue(input mode_type m, input vertex_type s, input vertex_type t);
      req_mode          <= m;
      req_source_vertex <= s;
      req_target_vertex <= t;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      visit_board.note_item(m, s, t);
      case (m)
         MODE_SEARCH: searches++;
         MODE_NONE:   ignored++;
         default:     edge_writes++;
      endcase
      idle_gap();
   endtask

   initial begin
      int         sent;
      int         r;
      int         add_pct;
      int         search_pct;
      int         chain_len;
      vertex_type chain [8];
      visit_board       = new();
      cycle_count       = 0;
      edge_writes       = 0;
      searches          = 0;
      ignored           = 0;
      steady_left       = 0;
      reset             = 1'b1;
      start             = 1'b0;
      req_mode          = MODE_ADD;
      req_source_vertex = '0;
      req_target_vertex = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty graph, extremes, self loop, ignored mode, revisit of a pushed vertex
      issue(MODE_SEARCH, 4'd0, 4'd15);
      issue(MODE_SEARCH, 4'd15, 4'd0);
      issue(MODE_ADD, 4'd5, 4'd5);
      issue(MODE_SEARCH, 4'd5, 4'd5);
      issue(MODE_ADD, 4'd0, 4'd1);
      issue(MODE_ADD, 4'd0, 4'd2);
      issue(MODE_ADD, 4'd2, 4'd1);
      issue(MODE_ADD, 4'd1, 4'd15);
      issue(MODE_ADD, 4'd15, 4'd0);
      issue(MODE_NONE, 4'd15, 4'd15);
      issue(MODE_SEARCH, 4'd0, 4'd0);
      issue(MODE_REMOVE, 4'd0, 4'd2);
      issue(MODE_REMOVE, 4'd3, 4'd3);
      issue(MODE_SEARCH, 4'd0, 4'd7);
      issue(MODE_SEARCH, 4'd15, 4'd15);
      issue(MODE_ADD, 4'd15, 4'd15);
      issue(MODE_SEARCH, 4'd15, 4'd9);
      issue(MODE_NONE, 4'd0, 4'd0);

      sent       = 0;
      add_pct    = 50;
      search_pct = 20;
      while (sent < RANDOM_ITEMS) begin
         // new graph density and search rate every few dozen commands
         if (sent % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       add_pct = 15;
               1:       add_pct = 50;
               default: add_pct = 85;
            endcase
            search_pct = $urandom_range(10, 30);
            if ($urandom_range(0, 2) == 0) steady_left = $urandom_range(10, 30);
         end
         r = $urandom_range(0, 99);
         if (r < 4) begin
            issue(MODE_NONE, vertex_type'($urandom), vertex_type'($urandom));
         end else if (r < 12) begin
            // build a path through random vertices, then search from its head
            chain_len = $urandom_range(3, 7);
            for (int i = 0; i <= chain_len; i++) chain[i] = vertex_type'($urandom);
            for (int i = 0; i < chain_len; i++) begin
               issue(MODE_ADD, chain[i], chain[i + 1]);
               sent++;
            end
            issue(MODE_SEARCH, chain[0], vertex_type'($urandom));
            sent++;
         end else if (r < 12 + search_pct) begin
            issue(MODE_SEARCH, vertex_type'($urandom), vertex_type'($urandom));
            sent++;
         end else begin
            if ($urandom_range(0, 99) < add_pct)
               issue(MODE_ADD, vertex_type'($urandom), vertex_type'($urandom));
            else
               issue(MODE_REMOVE, vertex_type'($urandom), vertex_type'($urandom));
            sent++;
         end
      end

      start <= 1'b0;
      while (visit_board.pending_visits() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (visit_board.pending_visits() > 0) begin
         visit_board.errors++;
         $display("%0t: %0d visits never arrived", $time, visit_board.pending_visits());
      end

      $display("Run covered %0d edge writes, %0d searches, %0d ignored commands;",
               edge_writes, searches, ignored);
      $display("%0d visits compared against the predicted depth-first order.",
               visit_board.checked);
      if (visit_board.errors == 0) begin
         $display("** adjacency_matrix_dfs_unit: PASSED **");
      end else begin
         $display("** adjacency_matrix_dfs_unit: FAILED **");
      end
      $finish;
   end

endmodule
